// ----- rtl/core/seat_run_first_fit_allocator_assert.svh -----
// ---------------------------------------------------------------------------
// Seat run allocator assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ---------------------------------------------------------------------------
`ifndef SEAT_RUN_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define SEAT_RUN_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define SRFFA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRFFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/srffa_pkg.sv -----
// ---------------------------------------------------------------------------
// Seat run allocator package
// Field widths, command codes and result status codes.
// ---------------------------------------------------------------------------
package srffa_pkg;

  localparam int RUN_LEN_W = 3;
  localparam int PICK_W    = 4;
  localparam int STATUS_W  = 3;
  localparam int FOUND_W   = 4;

  localparam logic CMD_AUTO   = 1'b0;
  localparam logic CMD_MANUAL = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_DECLINED = 3'd1,
    ST_NO_ROOM  = 3'd2,
    ST_TAKEN    = 3'd3,
    ST_INVALID  = 3'd4
  } status_e;

endpackage

// ----- rtl/core/srffa_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module srffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/srffa_fit.sv -----
// ---------------------------------------------------------------------------
// Row fit finder
// Find the lowest start column of a free run of the given length in a row.
// ---------------------------------------------------------------------------
module srffa_fit #(
  parameter int COL_COUNT = 8,
  localparam int CW       = $clog2(COL_COUNT)
) (
  input  logic [COL_COUNT-1:0]            row_i,
  input  logic [srffa_pkg::RUN_LEN_W-1:0] len_i,
  output logic                            found_o,
  output logic [CW-1:0]                   start_o,
  output logic [COL_COUNT-1:0]            mask_o
);

  logic [COL_COUNT-1:0] len_mask;

  assign len_mask = ~({COL_COUNT{1'b1}} << len_i);

  // Walk columns high to low so the lowest fitting start wins.
  always_comb begin
    logic [COL_COUNT-1:0] cand;
    found_o = 1'b0;
    start_o = '0;
    mask_o  = '0;
    for (int c = COL_COUNT - 1; c >= 0; c--) begin
      cand = len_mask << c;
      if ((c + int'(len_i) <= COL_COUNT) && ((row_i & cand) == '0)) begin
        found_o = 1'b1;
        start_o = CW'(c);
        mask_o  = cand;
      end
    end
  end

endmodule

// ----- rtl/core/seat_run_first_fit_allocator.sv -----
// ---------------------------------------------------------------------------
// Seat run first-fit allocator
// Grid of occupied bits with first-fit run search and single cell claims.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request
// gives exactly one result beat on status_o/row_found_o/col_found_o, marked by
// result_valid_o for a single cycle; the receiver cannot stall it, so capture
// it when the strobe is high. The occupancy grid lives in a RAM with one row
// per word and a registered read. An automatic request reads one row per
// cycle, lowest row first, until it finds a fit or has read all rows when
// there is no room; a manual claim reads its one row, then checks the cell
// and writes the row back if it was free; an invalid request or a run longer
// than a row answers straight from the idle state without touching the RAM.
// busy is low again in the cycle the result is shown, so the next request
// can be taken then. Per-row valid flags, cleared by reset, make every row
// read as free until first written; there is no clearing pass.
// ---------------------------------------------------------------------------
module seat_run_first_fit_allocator #(
  parameter int ROW_COUNT = 8,
  parameter int COL_COUNT = 8,
  parameter int MAX_RUN   = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            command_i,
  input  logic [srffa_pkg::RUN_LEN_W-1:0] run_length_i,
  input  logic                            accept_i,
  input  logic [srffa_pkg::PICK_W-1:0]    row_pick_i,
  input  logic [srffa_pkg::PICK_W-1:0]    col_pick_i,
  output logic                            result_valid_o,
  output logic [srffa_pkg::STATUS_W-1:0]  status_o,
  output logic [srffa_pkg::FOUND_W-1:0]   row_found_o,
  output logic [srffa_pkg::FOUND_W-1:0]   col_found_o
);

`include "seat_run_first_fit_allocator_assert.svh"

  localparam int AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int CW = $clog2(COL_COUNT);
  localparam logic [AW-1:0] LAST_ROW = AW'(ROW_COUNT - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MAN  = 2'd2;

  // Control state
  logic [1:0]           state_q, state_d;
  logic [ROW_COUNT-1:0] row_valid_q, row_valid_d;
  logic                 res_valid_q, res_valid_d;

  // Request and result payload
  logic [AW-1:0]                   row_q, row_d;
  logic [CW-1:0]                   col_q, col_d;
  logic [srffa_pkg::RUN_LEN_W-1:0] len_q, len_d;
  logic                            acc_q, acc_d;
  srffa_pkg::status_e              status_q, status_d;
  logic [srffa_pkg::FOUND_W-1:0]   row_out_q, row_out_d;
  logic [srffa_pkg::FOUND_W-1:0]   col_out_q, col_out_d;

  // RAM port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [COL_COUNT-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [COL_COUNT-1:0] ram_rdata;

  logic [COL_COUNT-1:0] row_word;
  logic                 fit_found;
  logic [CW-1:0]        fit_start;
  logic [COL_COUNT-1:0] fit_mask;
  logic [COL_COUNT-1:0] cell_mask;

  logic          take;
  logic          len_ok;
  logic          len_too_long;
  logic          pick_ok;
  logic [AW-1:0] pick_row;
  logic [CW-1:0] pick_col;
  logic [AW-1:0] row_next;
  logic [srffa_pkg::FOUND_W-1:0] row_one;
  logic [srffa_pkg::FOUND_W-1:0] col_one;
  logic [srffa_pkg::FOUND_W-1:0] fit_col_one;

  assign take = start && (state_q == S_IDLE);

  assign len_ok = (run_length_i != '0) && (4'(run_length_i) <= 4'(MAX_RUN));
  assign len_too_long = (5'(run_length_i) > 5'(COL_COUNT));
  assign pick_ok = (row_pick_i != '0) && (5'(row_pick_i) <= 5'(ROW_COUNT))
                && (col_pick_i != '0) && (5'(col_pick_i) <= 5'(COL_COUNT));
  assign pick_row = AW'(row_pick_i - 1'b1);
  assign pick_col = CW'(col_pick_i - 1'b1);

  assign row_next = (row_q == LAST_ROW) ? '0 : row_q + 1'b1;

  // A row never written reads as all free.
  assign row_word = row_valid_q[row_q] ? ram_rdata : '0;

  // 1-based result coordinates, truncated to the field width.
  assign row_one     = srffa_pkg::FOUND_W'(5'(row_q) + 5'd1);
  assign col_one     = srffa_pkg::FOUND_W'(5'(col_q) + 5'd1);
  assign fit_col_one = srffa_pkg::FOUND_W'(5'(fit_start) + 5'd1);

  assign cell_mask = COL_COUNT'(1) << col_q;

  srffa_ram #(
    .WIDTH(COL_COUNT),
    .DEPTH(ROW_COUNT)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  srffa_fit #(
    .COL_COUNT(COL_COUNT)
  ) u_fit (
    .row_i  (row_word),
    .len_i  (len_q),
    .found_o(fit_found),
    .start_o(fit_start),
    .mask_o (fit_mask)
  );

  always_comb begin
    state_d     = state_q;
    row_valid_d = row_valid_q;
    res_valid_d = 1'b0;
    row_d       = row_q;
    col_d       = col_q;
    len_d       = len_q;
    acc_d       = acc_q;
    status_d    = status_q;
    row_out_d   = row_out_q;
    col_out_d   = col_out_q;
    ram_we      = 1'b0;
    ram_waddr   = row_q;
    ram_wdata   = row_word;
    ram_raddr   = row_q;

    case (state_q)
      S_IDLE: begin
        // Issue the first row read together with the request beat.
        ram_raddr = (command_i == srffa_pkg::CMD_MANUAL) ? pick_row : '0;
        if (take) begin
          len_d = run_length_i;
          acc_d = accept_i;
          row_d = '0;
          col_d = pick_col;
          if (command_i == srffa_pkg::CMD_AUTO) begin
            if (!len_ok) begin
              res_valid_d = 1'b1;
              status_d    = srffa_pkg::ST_INVALID;
              row_out_d   = '0;
              col_out_d   = '0;
            end else if (len_too_long) begin
              res_valid_d = 1'b1;
              status_d    = srffa_pkg::ST_NO_ROOM;
              row_out_d   = '0;
              col_out_d   = '0;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            if (!pick_ok) begin
              res_valid_d = 1'b1;
              status_d    = srffa_pkg::ST_INVALID;
              row_out_d   = '0;
              col_out_d   = '0;
            end else begin
              row_d   = pick_row;
              state_d = S_MAN;
            end
          end
        end
      end
      S_SCAN: begin
        // Prefetch the next row while testing the current one.
        ram_raddr = row_next;
        if (fit_found) begin
          res_valid_d = 1'b1;
          row_out_d   = row_one;
          col_out_d   = fit_col_one;
          state_d     = S_IDLE;
          if (acc_q) begin
            ram_we              = 1'b1;
            ram_wdata           = row_word | fit_mask;
            row_valid_d[row_q]  = 1'b1;
            status_d            = srffa_pkg::ST_GRANTED;
          end else begin
            status_d = srffa_pkg::ST_DECLINED;
          end
        end else if (row_q == LAST_ROW) begin
          res_valid_d = 1'b1;
          status_d    = srffa_pkg::ST_NO_ROOM;
          row_out_d   = '0;
          col_out_d   = '0;
          state_d     = S_IDLE;
        end else begin
          row_d = row_next;
        end
      end
      S_MAN: begin
        res_valid_d = 1'b1;
        row_out_d   = row_one;
        col_out_d   = col_one;
        state_d     = S_IDLE;
        if ((row_word & cell_mask) != '0) begin
          status_d = srffa_pkg::ST_TAKEN;
        end else begin
          ram_we             = 1'b1;
          ram_wdata          = row_word | cell_mask;
          row_valid_d[row_q] = 1'b1;
          status_d           = srffa_pkg::ST_GRANTED;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_valid_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_valid_q <= row_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q     <= row_d;
    col_q     <= col_d;
    len_q     <= len_d;
    acc_q     <= acc_d;
    status_q  <= status_d;
    row_out_q <= row_out_d;
    col_out_q <= col_out_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign row_found_o    = row_out_q;
  assign col_found_o    = col_out_q;

  logic grant_beat;
  logic req_done;

  assign grant_beat = result_valid_o && (status_o == srffa_pkg::ST_GRANTED);
  assign req_done   = busy && (state_d == S_IDLE);

  // A granted beat always follows a map write-back.
  `SRFFA_ASSERT_SAME(a_grant_wrote, clk_i, rst_ni, grant_beat, $past(ram_we), "grant, no write")
  // Writes happen only while a request is in flight.
  `SRFFA_ASSERT_SAME(a_write_busy, clk_i, rst_ni, ram_we, busy, "map write while idle")
  // A busy cycle that returns to idle must produce a result beat.
  `SRFFA_ASSERT_NEXT(a_busy_ends, clk_i, rst_ni, req_done, result_valid_o, "no result at end")
  // The scan row stays inside the grid.
  `SRFFA_ASSERT_SAME(a_scan_row, clk_i, rst_ni, state_q == S_SCAN, row_q <= LAST_ROW, "bad scan row")

endmodule

// ----- tb/seat_run_first_fit_allocator_tb.sv -----
// ---------------------------------------------------------------------------
// Seat run first-fit allocator testbench
// Drives automatic run requests and manual cell claims through the start/busy
// handshake. A short table of directed requests comes first, then random
// requests. A local occupancy map predicts every result beat. Each strobed
// result is checked field by field against the oldest pending prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module seat_run_first_fit_allocator_tb;

  localparam int ROWS        = 8;
  localparam int COLS        = 8;
  localparam int MAXRUN      = 4;
  localparam int DIR_COUNT   = 19;
  localparam int RAND_COUNT  = 1700;
  localparam int TAIL_CYCLES = ROWS + 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                            cmd;
    logic [srffa_pkg::RUN_LEN_W-1:0] run_len;
    logic                            accept;
    logic [srffa_pkg::PICK_W-1:0]    row;
    logic [srffa_pkg::PICK_W-1:0]    col;
  } seat_req_t;

  typedef struct packed {
    srffa_pkg::status_e            status;
    logic [srffa_pkg::FOUND_W-1:0] row;
    logic [srffa_pkg::FOUND_W-1:0] col;
  } seat_res_t;

  // One row of the directed table; a typed-in result is used only when set.
  typedef struct packed {
    seat_req_t req;
    logic      typed;
    seat_res_t res;
  } dir_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start;
  logic                            busy;
  logic                            command_i;
  logic [srffa_pkg::RUN_LEN_W-1:0] run_length_i;
  logic                            accept_i;
  logic [srffa_pkg::PICK_W-1:0]    row_pick_i;
  logic [srffa_pkg::PICK_W-1:0]    col_pick_i;
  logic                            result_valid_o;
  logic [srffa_pkg::STATUS_W-1:0]  status_o;
  logic [srffa_pkg::FOUND_W-1:0]   row_found_o;
  logic [srffa_pkg::FOUND_W-1:0]   col_found_o;

  seat_run_first_fit_allocator #(
    .ROW_COUNT(ROWS),
    .COL_COUNT(COLS),
    .MAX_RUN  (MAXRUN)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .run_length_i  (run_length_i),
    .accept_i      (accept_i),
    .row_pick_i    (row_pick_i),
    .col_pick_i    (col_pick_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .row_found_o   (row_found_o),
    .col_found_o   (col_found_o)
  );

  // Local copy of the occupancy grid, one word per row, bit c is column c+1.
  logic [COLS-1:0] seat_map [ROWS];
  seat_res_t       pending_results [$];
  int              mismatch_count;
  int              result_count;
  int              cycle_count;
  int              status_tally [5];
  dir_row_t        directed_rows [DIR_COUNT];

  // Free-running clock, 8 ns period.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Predict the outcome of one accepted request and commit it to the grid.
  // First fit: lowest row first, then lowest start column within the row.
  function automatic seat_res_t claim_seats(input seat_req_t rq);
    seat_res_t   res;
    logic [15:0] mask;
    logic        hit;
    int          ri;
    int          ci;
    res = '{srffa_pkg::ST_INVALID, '0, '0};
    hit = 1'b0;
    if (rq.cmd == srffa_pkg::CMD_AUTO) begin
      if (rq.run_len < 1 || rq.run_len > MAXRUN) begin
        res = '{srffa_pkg::ST_INVALID, '0, '0};
      end else if (rq.run_len > COLS) begin
        // A run wider than a row can never fit.
        res = '{srffa_pkg::ST_NO_ROOM, '0, '0};
      end else begin
        res = '{srffa_pkg::ST_NO_ROOM, '0, '0};
        for (int r = 0; r < ROWS; r++) begin
          for (int c = 0; c + rq.run_len <= COLS; c++) begin
            mask = ((16'd1 << rq.run_len) - 16'd1) << c;
            if (!hit && ((16'(seat_map[r]) & mask) == 16'd0)) begin
              hit = 1'b1;
              res.row = srffa_pkg::FOUND_W'(r + 1);
              res.col = srffa_pkg::FOUND_W'(c + 1);
              if (rq.accept) begin
                res.status = srffa_pkg::ST_GRANTED;
                seat_map[r] = seat_map[r] | mask[COLS-1:0];
              end else begin
                // Declined offer: report the run, leave the grid alone.
                res.status = srffa_pkg::ST_DECLINED;
              end
            end
          end
        end
      end
    end else begin
      // Manual claim: accept and run length play no part.
      if (rq.row < 1 || rq.row > ROWS || rq.col < 1 || rq.col > COLS) begin
        res = '{srffa_pkg::ST_INVALID, '0, '0};
      end else begin
        ri = int'(rq.row) - 1;
        ci = int'(rq.col) - 1;
        if (seat_map[ri][ci]) begin
          res = '{srffa_pkg::ST_TAKEN, srffa_pkg::FOUND_W'(rq.row),
                  srffa_pkg::FOUND_W'(rq.col)};
        end else begin
          seat_map[ri][ci] = 1'b1;
          res = '{srffa_pkg::ST_GRANTED, srffa_pkg::FOUND_W'(rq.row),
                  srffa_pkg::FOUND_W'(rq.col)};
        end
      end
    end
    return res;
  endfunction

  // Present one request after an idle gap and hold it until the beat is taken.
  // Fields change on the falling edge; busy is sampled on the rising edge.
  task automatic send_request(input seat_req_t rq, input logic typed,
                              input seat_res_t typed_res, input int gap);
    seat_res_t predicted;
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start        <= 1'b1;
    command_i    <= rq.cmd;
    run_length_i <= rq.run_len;
    accept_i     <= rq.accept;
    row_pick_i   <= rq.row;
    col_pick_i   <= rq.col;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    // Beat taken: advance the local grid and queue the expected result.
    predicted = claim_seats(rq);
    status_tally[predicted.status]++;
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Result checker: every strobed beat must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      result_count++;
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending, status", int'(status_o), -1);
      end else begin
        if (status_o !== pending_results[0].status) begin
          flag_mismatch("status", int'(status_o), int'(pending_results[0].status));
        end
        if (row_found_o !== pending_results[0].row) begin
          flag_mismatch("row_found", int'(row_found_o), int'(pending_results[0].row));
        end
        if (col_found_o !== pending_results[0].col) begin
          flag_mismatch("col_found", int'(col_found_o), int'(pending_results[0].col));
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, pending_results.size());
      $display("seat_run_first_fit_allocator: mismatch");
      $finish;
    end
  end

  initial begin
    seat_req_t rq;
    int        gap;
    int        stretch;
    logic      in_range;

    // Drive every input to a known value before and during reset.
    rst_ni         = 1'b0;
    start          = 1'b0;
    command_i      = srffa_pkg::CMD_AUTO;
    run_length_i   = '0;
    accept_i       = 1'b0;
    row_pick_i     = '0;
    col_pick_i     = '0;
    mismatch_count = 0;
    result_count   = 0;
    cycle_count    = 0;
    foreach (seat_map[r]) seat_map[r] = '0;
    foreach (status_tally[s]) status_tally[s] = 0;

    // Directed table. Typed-in results only where they are plain from an empty
    // grid or an error; the rest go through the predictor.
    // Invalid run lengths, both extremes and just above the limit.
    directed_rows[0]  = '{'{srffa_pkg::CMD_AUTO, 3'd0, 1'b1, 4'd0, 4'd0}, 1'b1,
                          '{srffa_pkg::ST_INVALID, 4'd0, 4'd0}};
    directed_rows[1]  = '{'{srffa_pkg::CMD_AUTO, 3'd7, 1'b1, 4'd15, 4'd15}, 1'b1,
                          '{srffa_pkg::ST_INVALID, 4'd0, 4'd0}};
    directed_rows[2]  = '{'{srffa_pkg::CMD_AUTO, 3'd5, 1'b0, 4'd1, 4'd1}, 1'b1,
                          '{srffa_pkg::ST_INVALID, 4'd0, 4'd0}};
    // Declined offer on an empty grid: first run at row 1, column 1.
    directed_rows[3]  = '{'{srffa_pkg::CMD_AUTO, 3'd4, 1'b0, 4'd8, 4'd8}, 1'b1,
                          '{srffa_pkg::ST_DECLINED, 4'd1, 4'd1}};
    directed_rows[4]  = '{'{srffa_pkg::CMD_AUTO, 3'd1, 1'b1, 4'd0, 4'd0}, 1'b1,
                          '{srffa_pkg::ST_GRANTED, 4'd1, 4'd1}};
    directed_rows[5]  = '{'{srffa_pkg::CMD_AUTO, 3'd4, 1'b1, 4'd0, 4'd0}, 1'b0,
                          '{srffa_pkg::ST_GRANTED, 4'd0, 4'd0}};
    // Manual out of range: zero row, zero column, one past the grid, top code.
    directed_rows[6]  = '{'{srffa_pkg::CMD_MANUAL, 3'd1, 1'b0, 4'd0, 4'd1}, 1'b1,
                          '{srffa_pkg::ST_INVALID, 4'd0, 4'd0}};
    directed_rows[7]  = '{'{srffa_pkg::CMD_MANUAL, 3'd1, 1'b0, 4'd1, 4'd0}, 1'b1,
                          '{srffa_pkg::ST_INVALID, 4'd0, 4'd0}};
    directed_rows[8]  = '{'{srffa_pkg::CMD_MANUAL, 3'd2, 1'b1, 4'd9, 4'd1}, 1'b1,
                          '{srffa_pkg::ST_INVALID, 4'd0, 4'd0}};
    directed_rows[9]  = '{'{srffa_pkg::CMD_MANUAL, 3'd3, 1'b0, 4'd1, 4'd9}, 1'b1,
                          '{srffa_pkg::ST_INVALID, 4'd0, 4'd0}};
    directed_rows[10] = '{'{srffa_pkg::CMD_MANUAL, 3'd7, 1'b1, 4'd15, 4'd15}, 1'b1,
                          '{srffa_pkg::ST_INVALID, 4'd0, 4'd0}};
    // Far corner claimed, then claimed again.
    directed_rows[11] = '{'{srffa_pkg::CMD_MANUAL, 3'd0, 1'b0, 4'd8, 4'd8}, 1'b1,
                          '{srffa_pkg::ST_GRANTED, 4'd8, 4'd8}};
    directed_rows[12] = '{'{srffa_pkg::CMD_MANUAL, 3'd0, 1'b0, 4'd8, 4'd8}, 1'b1,
                          '{srffa_pkg::ST_TAKEN, 4'd8, 4'd8}};
    directed_rows[13] = '{'{srffa_pkg::CMD_MANUAL, 3'd4, 1'b1, 4'd1, 4'd1}, 1'b0,
                          '{srffa_pkg::ST_GRANTED, 4'd0, 4'd0}};
    // Manual claim with accept and run length set to odd values: ignored.
    directed_rows[14] = '{'{srffa_pkg::CMD_MANUAL, 3'd7, 1'b1, 4'd1, 4'd6}, 1'b0,
                          '{srffa_pkg::ST_GRANTED, 4'd0, 4'd0}};
    // Row 1 now has only two free cells at the end: spill to row 2.
    directed_rows[15] = '{'{srffa_pkg::CMD_AUTO, 3'd3, 1'b1, 4'd5, 4'd5}, 1'b0,
                          '{srffa_pkg::ST_GRANTED, 4'd0, 4'd0}};
    // Run that ends on the last column.
    directed_rows[16] = '{'{srffa_pkg::CMD_AUTO, 3'd2, 1'b1, 4'd0, 4'd0}, 1'b0,
                          '{srffa_pkg::ST_GRANTED, 4'd0, 4'd0}};
    directed_rows[17] = '{'{srffa_pkg::CMD_MANUAL, 3'd1, 1'b0, 4'd1, 4'd8}, 1'b0,
                          '{srffa_pkg::ST_GRANTED, 4'd0, 4'd0}};
    directed_rows[18] = '{'{srffa_pkg::CMD_AUTO, 3'd1, 1'b0, 4'd0, 4'd0}, 1'b0,
                          '{srffa_pkg::ST_GRANTED, 4'd0, 4'd0}};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIR_COUNT; i++) begin
      send_request(directed_rows[i].req, directed_rows[i].typed,
                   directed_rows[i].res, $urandom_range(0, 14));
    end

    // Random part. Grants are kept rare so the grid fills slowly over the
    // run and every fill level sees a mix of offers, claims and misses.
    for (int i = 0; i < RAND_COUNT; i++) begin
      rq.cmd     = ($urandom_range(0, 9) < 6) ? srffa_pkg::CMD_AUTO
                                              : srffa_pkg::CMD_MANUAL;
      rq.run_len = ($urandom_range(0, 9) == 0)
                 ? srffa_pkg::RUN_LEN_W'($urandom_range(0, 7))
                 : srffa_pkg::RUN_LEN_W'($urandom_range(1, MAXRUN));
      rq.accept  = ($urandom_range(0, 31) == 0);
      rq.row     = srffa_pkg::PICK_W'($urandom_range(0, 15));
      rq.col     = srffa_pkg::PICK_W'($urandom_range(0, 15));
      if (rq.cmd == srffa_pkg::CMD_MANUAL) begin
        // Hold most manual claims out of range; let a few hit real cells.
        if ($urandom_range(0, 7) == 0) begin
          rq.row = srffa_pkg::PICK_W'($urandom_range(1, ROWS));
          rq.col = srffa_pkg::PICK_W'($urandom_range(1, COLS));
        end else begin
          in_range = (rq.row >= 1 && rq.row <= ROWS && rq.col >= 1 && rq.col <= COLS);
          if (in_range) begin
            rq.col = ($urandom_range(0, 1) == 0)
                   ? srffa_pkg::PICK_W'(0)
                   : srffa_pkg::PICK_W'($urandom_range(COLS + 1, 15));
          end
        end
      end
      // Every fourth stretch of 128 requests runs back to back.
      stretch = (i / 128) % 4;
      gap     = (stretch == 3) ? 0 : $urandom_range(0, 14);
      send_request(rq, 1'b0, '{srffa_pkg::ST_GRANTED, 4'd0, 4'd0}, gap);
    end

    @(negedge clk_i);
    start <= 1'b0;

    // Drain: wait for the last result, then watch for strays.
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d requests, %0d results, %0d mismatches", DIR_COUNT + RAND_COUNT,
             result_count, mismatch_count);
    $display("granted %0d, declined %0d, no room %0d, taken %0d, invalid %0d",
             status_tally[srffa_pkg::ST_GRANTED], status_tally[srffa_pkg::ST_DECLINED],
             status_tally[srffa_pkg::ST_NO_ROOM], status_tally[srffa_pkg::ST_TAKEN],
             status_tally[srffa_pkg::ST_INVALID]);
    if (mismatch_count == 0) begin
      $display("seat_run_first_fit_allocator: match");
    end else begin
      $display("seat_run_first_fit_allocator: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/srffa_pkg.sv
rtl/core/srffa_ram.sv
rtl/core/srffa_fit.sv
rtl/core/seat_run_first_fit_allocator.sv
tb/seat_run_first_fit_allocator_tb.sv
